### design/cordic_pkg.sv
// shared constants and the arctangent table for the cordic pipeline
package cordic_pkg;

   // default pipeline shape
   localparam int ITERATIONS_DEFAULT = 16;
   localparam int DATA_WIDTH_DEFAULT = 32;
   localparam int MAX_ITERATIONS     = 16;

   // field widths of the request and response
   localparam int XY_IN_WIDTH    = 30;
   localparam int ANGLE_IN_WIDTH = 31;
   localparam int OUT_WIDTH      = 32;
   localparam int ATAN_WIDTH     = 16;

   // mode codes
   localparam logic OP_ROTATE = 1'b0;
   localparam logic OP_VECTOR = 1'b1;

   // atan(2^-k) in degrees times 256
   localparam logic [ATAN_WIDTH-1:0] ATAN_DEG [MAX_ITERATIONS] = '{
      16'h2D00, 16'h1A90, 16'h0E09, 16'h0720,
      16'h0393, 16'h01CA, 16'h00E5, 16'h0072,
      16'h0039, 16'h001C, 16'h000E, 16'h0007,
      16'h0003, 16'h0001, 16'h0000, 16'h0000
   };

endpackage

### design/cordic_ifs.sv
// request and response channel interfaces of the cordic block

// request channel: mode and starting vector and angle
interface cordic_req_if;
   logic                                               valid;
   logic                                               ready;
   logic                                               opcode;
   logic signed [cordic_pkg::XY_IN_WIDTH-1:0]          x_in;
   logic signed [cordic_pkg::XY_IN_WIDTH-1:0]          y_in;
   logic signed [cordic_pkg::ANGLE_IN_WIDTH-1:0]       angle_in;

   modport source (output valid, opcode, x_in, y_in, angle_in, input ready);
   modport sink   (input valid, opcode, x_in, y_in, angle_in, output ready);
endinterface

// response channel: final vector and angle
interface cordic_rsp_if;
   logic                                        valid;
   logic                                        ready;
   logic signed [cordic_pkg::OUT_WIDTH-1:0]     x_out;
   logic signed [cordic_pkg::OUT_WIDTH-1:0]     y_out;
   logic signed [cordic_pkg::OUT_WIDTH-1:0]     angle_out;

   modport source (output valid, x_out, y_out, angle_out, input ready);
   modport sink   (input valid, x_out, y_out, angle_out, output ready);
endinterface

### design/cordic_stage.sv
// one registered cordic micro-rotation with its own valid bit and stall control
module cordic_stage #(
   parameter int DATA_WIDTH = cordic_pkg::DATA_WIDTH_DEFAULT,
   parameter int STEP       = 0
) (
   input  logic                         clock,
   input  logic                         reset,
   // upstream side
   input  logic                         up_valid,
   output logic                         up_ready,
   input  logic                         up_opcode,
   input  logic signed [DATA_WIDTH-1:0] up_x,
   input  logic signed [DATA_WIDTH-1:0] up_y,
   input  logic signed [DATA_WIDTH-1:0] up_angle,
   // downstream side
   output logic                         dn_valid,
   input  logic                         dn_ready,
   output logic                         dn_opcode,
   output logic signed [DATA_WIDTH-1:0] dn_x,
   output logic signed [DATA_WIDTH-1:0] dn_y,
   output logic signed [DATA_WIDTH-1:0] dn_angle
);

   localparam logic [DATA_WIDTH-1:0] ATAN_STEP =
      DATA_WIDTH'(cordic_pkg::ATAN_DEG[STEP]);

   logic                         valid_ff, valid_in;
   logic                         opcode_ff;
   logic signed [DATA_WIDTH-1:0] x_ff, y_ff, angle_ff;
   logic signed [DATA_WIDTH-1:0] x_in, y_in, angle_in;
   logic signed [DATA_WIDTH-1:0] x_shift, y_shift, steer;
   logic                         clockwise;
   logic                         load;

   // stage takes a new request when empty or when its content moves on
   assign up_ready = !valid_ff || dn_ready;
   assign load     = up_ready && up_valid;
   assign valid_in = up_ready ? up_valid : valid_ff;

   // micro-rotation; a zero steering value leaves everything as it is
   always_comb begin
      x_shift   = up_x >>> STEP;
      y_shift   = up_y >>> STEP;
      steer     = (up_opcode == cordic_pkg::OP_VECTOR) ? up_y : up_angle;
      clockwise = (up_opcode == cordic_pkg::OP_VECTOR) == !steer[DATA_WIDTH-1];
      if (steer == '0) begin
         x_in     = up_x;
         y_in     = up_y;
         angle_in = up_angle;
      end else if (clockwise) begin
         x_in     = up_x + y_shift;
         y_in     = up_y - x_shift;
         angle_in = up_angle + $signed(ATAN_STEP);
      end else begin
         x_in     = up_x - y_shift;
         y_in     = up_y + x_shift;
         angle_in = up_angle - $signed(ATAN_STEP);
      end
   end

   // valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (load) begin
         opcode_ff <= up_opcode;
         x_ff      <= x_in;
         y_ff      <= y_in;
         angle_ff  <= angle_in;
      end
   end

   assign dn_valid  = valid_ff;
   assign dn_opcode = opcode_ff;
   assign dn_x      = x_ff;
   assign dn_y      = y_ff;
   assign dn_angle  = angle_ff;

endmodule

### design/cordic_rotate_vector_degrees.sv
// top level of the pipelined circular cordic, rotation and vectoring in degrees

// Circular CORDIC over signed x, y and an angle in degrees times 256. A request
// with opcode 0 rotates (x, y) so that the angle goes to zero; opcode 1 vectors,
// driving y to zero so that x ends as the magnitude times about 1.647 and the
// angle collects the arctangent. The gain is not compensated. There is one
// register stage per micro-rotation, so a request passes through ITERATIONS
// stages, and a new request is taken every cycle unless the request side stalls;
// the last stage doubles as the response register. When the response is held
// off, empty stages keep filling, and the request side stalls only once every
// stage holds an item.
module cordic_rotate_vector_degrees #(
   parameter int ITERATIONS = cordic_pkg::ITERATIONS_DEFAULT,
   parameter int DATA_WIDTH = cordic_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   cordic_req_if.sink        req_chan,
   cordic_rsp_if.source      rsp_chan
);

   logic                         valid_s  [ITERATIONS+1];
   logic                         ready_s  [ITERATIONS+1];
   logic                         opcode_s [ITERATIONS+1];
   logic signed [DATA_WIDTH-1:0] x_s      [ITERATIONS+1];
   logic signed [DATA_WIDTH-1:0] y_s      [ITERATIONS+1];
   logic signed [DATA_WIDTH-1:0] angle_s  [ITERATIONS+1];
   logic [ITERATIONS-1:0]        busy_vec;

   // request into the first stage, resized to the datapath width
   assign valid_s[0]   = req_chan.valid;
   assign req_chan.ready = ready_s[0];
   assign opcode_s[0]  = req_chan.opcode;

   if (DATA_WIDTH >= cordic_pkg::XY_IN_WIDTH) begin : g_xy_ext
      assign x_s[0] = DATA_WIDTH'(req_chan.x_in);
      assign y_s[0] = DATA_WIDTH'(req_chan.y_in);
   end else begin : g_xy_trunc
      assign x_s[0] = req_chan.x_in[DATA_WIDTH-1:0];
      assign y_s[0] = req_chan.y_in[DATA_WIDTH-1:0];
   end

   if (DATA_WIDTH >= cordic_pkg::ANGLE_IN_WIDTH) begin : g_ang_ext
      assign angle_s[0] = DATA_WIDTH'(req_chan.angle_in);
   end else begin : g_ang_trunc
      assign angle_s[0] = req_chan.angle_in[DATA_WIDTH-1:0];
   end

   // one stage per micro-rotation
   for (genvar g = 0; g < ITERATIONS; g++) begin : g_stage
      cordic_stage #(
         .DATA_WIDTH (DATA_WIDTH),
         .STEP       (g)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .up_valid  (valid_s[g]),
         .up_ready  (ready_s[g]),
         .up_opcode (opcode_s[g]),
         .up_x      (x_s[g]),
         .up_y      (y_s[g]),
         .up_angle  (angle_s[g]),
         .dn_valid  (valid_s[g+1]),
         .dn_ready  (ready_s[g+1]),
         .dn_opcode (opcode_s[g+1]),
         .dn_x      (x_s[g+1]),
         .dn_y      (y_s[g+1]),
         .dn_angle  (angle_s[g+1])
      );
      assign busy_vec[g] = valid_s[g+1];
   end

   // last stage drives the response
   assign rsp_chan.valid      = valid_s[ITERATIONS];
   assign ready_s[ITERATIONS] = rsp_chan.ready;

   if (DATA_WIDTH >= cordic_pkg::OUT_WIDTH) begin : g_out_trunc
      assign rsp_chan.x_out     = x_s[ITERATIONS][cordic_pkg::OUT_WIDTH-1:0];
      assign rsp_chan.y_out     = y_s[ITERATIONS][cordic_pkg::OUT_WIDTH-1:0];
      assign rsp_chan.angle_out = angle_s[ITERATIONS][cordic_pkg::OUT_WIDTH-1:0];
   end else begin : g_out_ext
      assign rsp_chan.x_out     = cordic_pkg::OUT_WIDTH'(x_s[ITERATIONS]);
      assign rsp_chan.y_out     = cordic_pkg::OUT_WIDTH'(y_s[ITERATIONS]);
      assign rsp_chan.angle_out = cordic_pkg::OUT_WIDTH'(angle_s[ITERATIONS]);
   end

`ifndef SYNTHESIS
   // request side backs up only when the whole pipe is full and the response waits
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> (&busy_vec) && rsp_chan.valid && !rsp_chan.ready)
      else $error("request stalled while the pipeline has room");

   // pipe is empty right after reset
   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> (busy_vec == '0))
      else $error("pipeline holds items after reset");

   // occupancy grows by at most one item per cycle
   a_fill_rate: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> ($countones(busy_vec) <= $countones($past(busy_vec)) + 1))
      else $error("pipeline occupancy jumped by more than one");
`endif

endmodule
